FILE: rtl/core/rgbm3_pkg.sv
package rgbm3_pkg;

   // Widest image row the line stores hold; sets the column counter and address width.
   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CFG_W       = 12;
   localparam int POS_W       = 11;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int PIX_W       = NUM_CHAN * CHAN_W;
   localparam int MIN_DIM     = 3;
   localparam int HEIGHT_MAX  = 2048;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_BAND_FIRST_ROW = 2'd2,
      CSR_BAND_END_ROW   = 2'd3
   } csr_index_type;

   typedef logic [CHAN_W-1:0] sample_type;

   // One window column of one channel, sorted ascending: [0] is the smallest.
   typedef sample_type [2:0] trio_type;

   // Packs as {red, green, blue}, the line store word layout.
   typedef struct packed {
      logic [CHAN_W-1:0] pix_red;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_blue;
   } req_pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] med_red;
      logic [CHAN_W-1:0] med_green;
      logic [CHAN_W-1:0] med_blue;
      logic [POS_W-1:0]  centre_row;
      logic [POS_W-1:0]  centre_col;
   } rsp_result_type;

endpackage

FILE: rtl/core/rgb_median_3x3_filter.sv
// Channel | direction | handshake            | payload
// req_    | in        | req_valid/req_stall  | req_pixel  (pix_blue, pix_green, pix_red)
// rsp_    | out       | rsp_valid/rsp_stall  | rsp_result (med_*, centre_col, centre_row)
// csr_    | in        | csr_write_en         | csr_index, csr_wdata (12 bits)
//
// Throughput: one pixel per clock while req_stall is low. After the transfer of the
// pixel that completes its window, its result passes through line store read, column
// sort into the window and the median network into the result register.
// Reset is synchronous and clears control state only; the line stores hold no reset
// value and need no clearing pass, so pixels are taken from the first cycle after reset.
// With rsp_stall held, up to two more pixels are taken behind a waiting result before
// req_stall rises; a window that yields no result leaves the middle stage without
// waiting on the output.
module rgb_median_3x3_filter
   import rgbm3_pkg::*;
(
   input  logic           clock,
   input  logic           reset,

   input  logic           req_valid,
   output logic           req_stall,
   input  req_pixel_type  req_pixel,

   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_result_type rsp_result,

   input  logic           csr_write_en,
   input  logic [1:0]     csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam logic [CFG_W-1:0] WIDTH_HI  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_HI = CFG_W'(HEIGHT_MAX);
   localparam logic [CFG_W-1:0] DIM_LO    = CFG_W'(MIN_DIM);
   localparam logic [CFG_W-1:0] ONE_CFG   = CFG_W'(1);

   // ---------------------------------------------------------------------------------
   // Sorting helpers
   // ---------------------------------------------------------------------------------
   function automatic trio_type sort3(input sample_type a, input sample_type b,
                                      input sample_type c);
      sample_type p0, p1, p2, t;
      p0 = a;
      p1 = b;
      p2 = c;
      if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
      if (p0 > p1) begin t = p0; p0 = p1; p1 = t; end
      if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
      return {p2, p1, p0};
   endfunction

   // Median of three pre-sorted columns: tail of the classic 19-exchange median-of-9.
   function automatic sample_type med9(input trio_type c0, input trio_type c1,
                                       input trio_type c2);
      sample_type p [9];
      sample_type t;
      p[0] = c0[0]; p[1] = c0[1]; p[2] = c0[2];
      p[3] = c1[0]; p[4] = c1[1]; p[5] = c1[2];
      p[6] = c2[0]; p[7] = c2[1]; p[8] = c2[2];
      if (p[0] > p[3]) begin t = p[0]; p[0] = p[3]; p[3] = t; end
      if (p[5] > p[8]) begin t = p[5]; p[5] = p[8]; p[8] = t; end
      if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
      if (p[3] > p[6]) begin t = p[3]; p[3] = p[6]; p[6] = t; end
      if (p[1] > p[4]) begin t = p[1]; p[1] = p[4]; p[4] = t; end
      if (p[2] > p[5]) begin t = p[2]; p[2] = p[5]; p[5] = t; end
      if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
      if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
      if (p[6] > p[4]) begin t = p[6]; p[6] = p[4]; p[4] = t; end
      if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
      return p[4];
   endfunction

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [CFG_W-1:0] width_ff, height_ff, band_first_ff, band_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= CFG_W'(640);
         height_ff     <= CFG_W'(480);
         band_first_ff <= '0;
         band_end_ff   <= CFG_W'(2048);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:    width_ff      <= csr_wdata;
            CSR_IMAGE_HEIGHT:   height_ff     <= csr_wdata;
            CSR_BAND_FIRST_ROW: band_first_ff <= csr_wdata;
            CSR_BAND_END_ROW:   band_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamped geometry and filter band
   logic [CFG_W-1:0] width_eff, height_eff, height_m1, band_first_eff, band_end_eff;

   always_comb begin
      if (width_ff < DIM_LO)         width_eff = DIM_LO;
      else if (width_ff > WIDTH_HI)  width_eff = WIDTH_HI;
      else                           width_eff = width_ff;

      if (height_ff < DIM_LO)        height_eff = DIM_LO;
      else if (height_ff > HEIGHT_HI) height_eff = HEIGHT_HI;
      else                           height_eff = height_ff;

      height_m1      = height_eff - ONE_CFG;
      band_first_eff = (band_first_ff < ONE_CFG) ? ONE_CFG : band_first_ff;
      band_end_eff   = (band_end_ff > height_m1) ? height_m1 : band_end_ff;
   end

   // ---------------------------------------------------------------------------------
   // Pipeline flow control
   //   stage A: line store read data + incoming pixel
   //   stage B: window of sorted columns
   //   stage C: result register
   // ---------------------------------------------------------------------------------
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic a_prod_ff, b_prod_ff;
   logic req_accept, a_move, b_move, b_free, c_free, c_take;

   assign c_take     = rsp_valid_ff && !rsp_stall;
   assign c_free     = !rsp_valid_ff || !rsp_stall;
   // A window that yields no result leaves stage B without waiting on the output.
   assign b_move     = b_valid_ff && (!b_prod_ff || c_free);
   assign b_free     = !b_valid_ff || b_move;
   assign a_move     = a_valid_ff && b_free;
   assign req_stall  = a_valid_ff && !b_free;
   assign req_accept = req_valid && !req_stall;

   assign a_valid_in   = req_accept || (a_valid_ff && !a_move);
   assign b_valid_in   = a_move || (b_valid_ff && !b_move);
   assign rsp_valid_in = (b_move && b_prod_ff) || (rsp_valid_ff && !c_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Raster position of the next pixel
   // ---------------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic             col_last, row_last;
   logic [CFG_W-1:0] centre_row_w;
   logic             prod_in;

   assign col_last     = ({1'b0, col_ff} + ONE_CFG) >= width_eff;
   assign row_last     = ({1'b0, row_ff} + ONE_CFG) >= height_eff;
   assign centre_row_w = {1'b0, row_ff} - ONE_CFG;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Window complete (from the third column and the third row onward) and centre row inside band
   assign prod_in = (col_ff >= COL_W'(2)) && (row_ff >= POS_W'(2))
                 && (centre_row_w >= band_first_eff) && (centre_row_w < band_end_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage A: line stores. Read at transfer, write back when the pixel leaves stage A.
   // Consecutive pixels never share a column (width is at least 3), so the write of
   // one pixel never collides with the read of the next.
   // ---------------------------------------------------------------------------------
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff, mid_rd_ff, a_pix_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [POS_W-1:0] a_row_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_rd_ff  <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (a_move) begin
         upper_mem[a_col_ff]  <= mid_rd_ff;
         middle_mem[a_col_ff] <= a_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_pix_ff  <= req_pixel;
         a_col_ff  <= col_ff;
         a_row_ff  <= row_ff;
         a_prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage B: window of three columns, each sorted per channel as it enters.
   // Index [channel][column]; column 2 is the newest. Channel 0 is blue.
   // ---------------------------------------------------------------------------------
   trio_type         win_ff [NUM_CHAN][3];
   trio_type         new_col [NUM_CHAN];
   logic [POS_W-1:0] b_col_ff, b_row_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         new_col[ch] = sort3(up_rd_ff[CHAN_W*ch +: CHAN_W],
                             mid_rd_ff[CHAN_W*ch +: CHAN_W],
                             a_pix_ff[CHAN_W*ch +: CHAN_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            win_ff[ch][0] <= win_ff[ch][1];
            win_ff[ch][1] <= win_ff[ch][2];
            win_ff[ch][2] <= new_col[ch];
         end
         b_col_ff  <= POS_W'(a_col_ff) - POS_W'(1);
         b_row_ff  <= a_row_ff - POS_W'(1);
         b_prod_ff <= a_prod_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage C: median network into the result register
   // ---------------------------------------------------------------------------------
   sample_type     med [NUM_CHAN];
   rsp_result_type rsp_result_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         med[ch] = med9(win_ff[ch][0], win_ff[ch][1], win_ff[ch][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (b_move && b_prod_ff) begin
         rsp_result_ff.med_blue   <= med[0];
         rsp_result_ff.med_green  <= med[1];
         rsp_result_ff.med_red    <= med[2];
         rsp_result_ff.centre_col <= b_col_ff;
         rsp_result_ff.centre_row <= b_row_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   // Write-back of the pixel in stage A never hits the column being read.
   assert property (@(posedge clock) disable iff (reset)
      (a_move && req_accept) |-> (a_col_ff != col_ff))
      else $error("line store write and read at the same column");

   // Input only stalls when stages A and B and the result register are all occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   // The last pixel of a row sends the column counter back to zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && col_last) |=> (col_ff == '0))
      else $error("column counter did not wrap at row end");

   // Every result comes from an interior centre pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.centre_col != '0 && rsp_result_ff.centre_row != '0))
      else $error("result for a border pixel");

endmodule

FILE: sim/rgb_median_checker.sv
// Watches the pixel, result and register ports, keeps its own image of the
// filter state and checks every result transfer against the oldest pending median.
module rgb_median_checker
   import rgbm3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_pixel_type    req_pixel,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_result_type   rsp_result,
   input  logic             csr_write_en,
   input  csr_index_type    csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               fail_count,
   output int               results_due,
   output int unsigned      next_col,
   output int unsigned      next_row
);

   localparam logic [CFG_W-1:0] WIDTH_AT_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_AT_RESET = 12'd480;
   localparam logic [CFG_W-1:0] END_AT_RESET    = 12'd2048;

   logic [CFG_W-1:0] width_cfg;
   logic [CFG_W-1:0] height_cfg;
   logic [CFG_W-1:0] first_cfg;
   logic [CFG_W-1:0] end_cfg;

   // Never-written entries stay X, so a stray read shows up in the compare.
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line [MAX_WIDTH];
   logic [PIX_W-1:0] window [9];
   int unsigned      col_pos;
   int unsigned      row_pos;

   rsp_result_type   medians_due [$];

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                             input int unsigned ceiling);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > ceiling) return ceiling;
      return v;
   endfunction

   // Median of one channel (bit offset shift) over the nine window pixels.
   function automatic sample_type window_median(input int shift);
      sample_type v [9];
      sample_type t;
      int         j;
      for (int i = 0; i < 9; i++) v[i] = sample_type'(window[i] >> shift);
      for (int i = 1; i < 9; i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > t) begin
            v[j + 1] = v[j];
            j--;
         end
         v[j + 1] = t;
      end
      return v[4];
   endfunction

   task automatic filter_pixel(input req_pixel_type px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      slot;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      rsp_result_type   res;
      w    = clamp_dim(width_cfg, MAX_WIDTH);
      h    = clamp_dim(height_cfg, HEIGHT_MAX);
      slot = col_pos % MAX_WIDTH;
      up   = upper_line[slot];
      mid  = middle_line[slot];
      for (int r = 0; r < 3; r++) begin
         window[3 * r]     = window[3 * r + 1];
         window[3 * r + 1] = window[3 * r + 2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = px;
      upper_line[slot]  = mid;
      middle_line[slot] = px;
      if (col_pos >= 2 && row_pos >= 2) begin
         lo = (first_cfg < 1) ? 1 : first_cfg;
         hi = (end_cfg > h - 1) ? h - 1 : end_cfg;
         if (row_pos - 1 >= lo && row_pos - 1 < hi) begin
            res.med_blue   = window_median(0);
            res.med_green  = window_median(CHAN_W);
            res.med_red    = window_median(2 * CHAN_W);
            res.centre_col = POS_W'(col_pos - 1);
            res.centre_row = POS_W'(row_pos - 1);
            medians_due.push_back(res);
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic check_result(input rsp_result_type got);
      rsp_result_type want;
      if (medians_due.size() == 0) begin
         if (fail_count < 10)
            $display("result with none pending: col %0d row %0d bgr %02h %02h %02h",
                     got.centre_col, got.centre_row,
                     got.med_blue, got.med_green, got.med_red);
         fail_count <= fail_count + 1;
      end else begin
         want = medians_due.pop_front();
         if (got.med_blue !== want.med_blue || got.med_green !== want.med_green ||
             got.med_red !== want.med_red || got.centre_col !== want.centre_col ||
             got.centre_row !== want.centre_row) begin
            if (fail_count < 10)
               $display({"median mismatch: expected col %0d row %0d bgr %02h %02h %02h,",
                         " got col %0d row %0d bgr %02h %02h %02h"},
                        want.centre_col, want.centre_row,
                        want.med_blue, want.med_green, want.med_red,
                        got.centre_col, got.centre_row,
                        got.med_blue, got.med_green, got.med_red);
            fail_count <= fail_count + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_cfg  = WIDTH_AT_RESET;
         height_cfg = HEIGHT_AT_RESET;
         first_cfg  = '0;
         end_cfg    = END_AT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         for (int i = 0; i < 9; i++) window[i] = '0;
         medians_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:    width_cfg  = csr_wdata;
               CSR_IMAGE_HEIGHT:   height_cfg = csr_wdata;
               CSR_BAND_FIRST_ROW: first_cfg  = csr_wdata;
               CSR_BAND_END_ROW:   end_cfg    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) filter_pixel(req_pixel);
         if (rsp_valid && !rsp_stall) check_result(rsp_result);
      end
      results_due <= medians_due.size();
      next_col    <= col_pos;
      next_row    <= row_pos;
   end

endmodule

FILE: sim/tb_rgb_median_3x3_filter.sv
// Stimulus and verdict for the 3x3 RGB median filter. All prediction and
// comparison lives in rgb_median_checker; this module only feeds pixels,
// drives rsp_stall, writes registers between phases, decides pass or fail.
module tb_rgb_median_3x3_filter;
   import rgbm3_pkg::*;

   // A run is about 2k pixel transfers plus register writes, drains and
   // stalls; this limit ends a run that never finishes as a failure.
   localparam int unsigned CYCLE_LIMIT  = 250000;
   localparam int unsigned RANDOM_ITEMS = 2000;
   // Pipeline depth from the head of the block, plus some slack.
   localparam int unsigned SETTLE       = 4;

   // Corner values for the first frame: both extremes in every channel.
   localparam logic [PIX_W-1:0] CORNER_FRAME [9] = '{
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h000000,
      24'h7F807F, 24'h01FE01, 24'h8040C0, 24'h00FFFF
   };

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_stall;
   req_pixel_type    req_pixel    = '0;
   logic             rsp_valid;
   logic             rsp_stall    = 1'b0;
   rsp_result_type   rsp_result;
   logic             csr_write_en = 1'b0;
   csr_index_type    csr_index    = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata    = '0;

   int               fail_count;
   int               results_due;
   int unsigned      next_col;
   int unsigned      next_row;

   // calm switches off idling on both sides for a stretch of phases.
   bit               calm         = 1'b0;
   int unsigned      cycles       = 0;

   // Shadow of what was written to the size registers, used to keep
   // mid-frame width changes from reading line store entries never filled.
   logic [CFG_W-1:0] width_reg    = 12'd640;
   logic [CFG_W-1:0] height_reg   = 12'd480;

   rgb_median_3x3_filter i_dut (.*);

   rgb_median_checker i_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: stalls at random about 9 percent of the time, never while calm.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                             input int unsigned ceiling);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > ceiling) return ceiling;
      return v;
   endfunction

   // Full-range noise half the time, with saturated channels and near-ties mixed
   // in so that the sort sees equal keys often.
   function automatic req_pixel_type random_pixel();
      req_pixel_type px;
      case ($urandom_range(3))
         2: begin
            px.pix_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            px.pix_green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.pix_red   = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         3: begin
            px.pix_blue  = 8'($urandom_range(120, 123));
            px.pix_green = 8'($urandom_range(120, 123));
            px.pix_red   = 8'($urandom_range(120, 123));
         end
         default: px = PIX_W'($urandom);
      endcase
      return px;
   endfunction

   // Image size: mostly small, sometimes below the minimum, huge or any
   // 12-bit value (clamped by the block).
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(15))
         0:       return CFG_W'($urandom_range(0, 2));
         1:       return 12'hFFF;
         2, 3:    return CFG_W'($urandom_range(13, 64));
         4:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(3, 12));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_row();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 12'hFFF;
         2:       return CFG_W'($urandom);
         3:       return 12'd2048;
         default: return CFG_W'($urandom_range(0, 8));
      endcase
   endfunction

   // One register write. A wider row is only allowed at a frame boundary:
   // mid-frame, the rows above would not have been stored that far out.
   task automatic set_reg(input csr_index_type idx, input logic [CFG_W-1:0] value);
      if (idx == CSR_IMAGE_WIDTH &&
          clamp_dim(value, MAX_WIDTH) > clamp_dim(width_reg, MAX_WIDTH) &&
          (next_col != 0 || next_row != 0))
         return;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      if (idx == CSR_IMAGE_HEIGHT) height_reg = value;
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // One pixel transfer; valid stays up across back-to-back calls and the
   // payload holds while stalled.
   task automatic send_pixel(input req_pixel_type px);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender holds off until every pending median has arrived, then lets the
   // pipeline empty so a register write cannot land on work in flight.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned count;
      int unsigned w;
      int unsigned h;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a single 3x3 frame from out-of-range sizes (both clamp to
      // three) with corner values, one median expected.
      set_reg(CSR_IMAGE_WIDTH, 12'd0);
      set_reg(CSR_IMAGE_HEIGHT, 12'd0);
      set_reg(CSR_BAND_FIRST_ROW, 12'd0);
      set_reg(CSR_BAND_END_ROW, 12'hFFF);
      for (int i = 0; i < 9; i++) send_pixel(req_pixel_type'(CORNER_FRAME[i]));
      drain();

      // Next frame wraps over stale line stores with an empty band: no results.
      set_reg(CSR_BAND_FIRST_ROW, 12'hFFF);
      for (int i = 0; i < 9; i++) send_pixel(random_pixel());
      drain();

      // Full band again before the random phases.
      set_reg(CSR_BAND_FIRST_ROW, 12'd0);
      set_reg(CSR_BAND_END_ROW, 12'd2048);

      // Random phases: new settings between bursts, some of them written in
      // the middle of a frame, some bursts run exactly to the frame end so
      // the following phase can widen the rows.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = (phase >= 4 && phase < 8);
         if ($urandom_range(1)) set_reg(CSR_IMAGE_WIDTH, pick_dim());
         if ($urandom_range(1)) set_reg(CSR_IMAGE_HEIGHT, pick_dim());
         if ($urandom_range(2) == 0) set_reg(CSR_BAND_FIRST_ROW, pick_row());
         if ($urandom_range(2) == 0) set_reg(CSR_BAND_END_ROW, pick_row());
         w = clamp_dim(width_reg, MAX_WIDTH);
         h = clamp_dim(height_reg, HEIGHT_MAX);
         if ($urandom_range(2) == 0) begin
            // pixels left in the frame; a shrunk row ends on its next pixel
            count = (next_col + 1 >= w) ? 1 : w - next_col;
            if (next_row + 1 < h) count += (h - 1 - next_row) * w;
            if (count > 400) count = $urandom_range(10, 150);
         end else begin
            count = $urandom_range(5, 150);
         end
         repeat (count) send_pixel(random_pixel());
         sent += count;
         drain();
         phase++;
      end
      calm = 1'b0;

      repeat (2 * SETTLE) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/rgbm3_pkg.sv
rtl/core/rgb_median_3x3_filter.sv
sim/rgb_median_checker.sv
sim/tb_rgb_median_3x3_filter.sv
